/* design/lts_pkg.sv */
// Package for the lexical token scanner: token classes, error codes,
// scan modes and character helpers. No dependencies.
`timescale 1ns / 1ps
package lts_pkg;
    localparam logic [2:0] CLS_KEYWORD = 3'd0;
    localparam logic [2:0] CLS_DELIM   = 3'd1;
    localparam logic [2:0] CLS_ARITH   = 3'd2;
    localparam logic [2:0] CLS_REL     = 3'd3;
    localparam logic [2:0] CLS_CONST   = 3'd4;
    localparam logic [2:0] CLS_IDENT   = 3'd5;
    localparam logic [2:0] CLS_ERROR   = 3'd6;

    localparam logic [15:0] ERR_BADCHAR   = 16'd0;
    localparam logic [15:0] ERR_TOOLONG   = 16'd1;
    localparam logic [15:0] ERR_TABLEFULL = 16'd2;
    localparam logic [15:0] ERR_LONECOLON = 16'd3;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_NUMBER  = 2'd2;
    localparam logic [1:0] MODE_PENDING = 2'd3;

    localparam logic [1:0] PEND_COLON = 2'd0;
    localparam logic [1:0] PEND_LT    = 2'd1;
    localparam logic [1:0] PEND_EQ    = 2'd2;
    localparam logic [1:0] PEND_GT    = 2'd3;

    localparam int KW_COUNT   = 8;
    localparam int KW_MAX_LEN = 8;

    // keyword texts, space padded, first character in the top byte
    typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        "if      ", "else    ", "for     ", "while   ",
        "do      ", "return  ", "break   ", "continue"};
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd5, 4'd8};

    typedef struct packed {
        logic [2:0]  cls;
        logic [15:0] idx;
        logic [7:0]  bad;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
endpackage

/* design/lexical_token_scanner_unit.sv */
// Lexical token scanner top level: byte scanner, word buffer and
// identifier table held in synchronous memories. Depends on lts_pkg.
`timescale 1ns / 1ps
// Bytes enter on ch/end_of_text and tokens leave on the output channel,
// at most two tokens per byte, last_of_run marking the final one. A byte
// that only extends a word or a constant, or is silent, raises no stall;
// a byte that yields tokens holds stall until the receiver has taken its
// token beats. A finished word first loads the keyword buffer and is then
// matched. A word that is not a keyword then costs a search of the
// identifier table: for each stored entry its length is read and checked,
// then its characters are compared one at a time, over the single read
// port of the character memory; a new entry is copied in one character
// at a time. The word buffer and the table need no clearing pass.
module lexical_token_scanner_unit #(
    parameter int TABLE_DEPTH  = 32,
    parameter int MAX_WORD_LEN = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        stall,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_class,
    output logic [15:0] token_index,
    output logic [7:0]  bad_char,
    output logic        last_of_run
);
    import lts_pkg::*;

    localparam int WW = $clog2(MAX_WORD_LEN);
    localparam int LW = $clog2(MAX_WORD_LEN + 2);
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = TW + WW;

    // sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EMIT   = 4'd1;
    localparam logic [3:0] ST_KW     = 4'd2;
    localparam logic [3:0] ST_LEN    = 4'd3;
    localparam logic [3:0] ST_LENCHK = 4'd4;
    localparam logic [3:0] ST_CMP    = 4'd5;
    localparam logic [3:0] ST_CMPCHK = 4'd6;
    localparam logic [3:0] ST_COPY   = 4'd7;
    localparam logic [3:0] ST_COPYWR = 4'd8;
    localparam logic [3:0] ST_KWRD   = 4'd9;

    // memories
    logic [7:0]    word_mem [MAX_WORD_LEN];
    logic [7:0]    ident_mem [TABLE_DEPTH*MAX_WORD_LEN];
    logic [LW-1:0] len_mem [TABLE_DEPTH];

    logic [3:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [LW-1:0] wlen_reg, wlen_next;
    logic [15:0]   num_reg, num_next;
    logic [1:0]    pend_reg, pend_next;
    logic [CW-1:0] icount_reg, icount_next;
    logic [CW-1:0] entry_reg, entry_next;
    logic [WW:0]   pos_reg, pos_next;
    // byte kept for rescan after a word ends
    logic [7:0]    hold_ch_reg, hold_ch_next;
    logic          hold_end_reg, hold_end_next;
    logic          out_valid_reg;
    token_t        tok_reg [2];
    token_t        tok_next [2];
    logic [1:0]    ntok_reg, ntok_next;
    logic          osel_reg, osel_next;

    // memory port controls
    logic          wm_we;
    logic [WW-1:0] wm_waddr, wm_raddr;
    logic [7:0]    wm_wdata, wm_rdata;
    logic          im_we;
    logic [AW-1:0] im_waddr, im_raddr;
    logic [7:0]    im_rdata;
    logic          lm_we;
    logic [LW-1:0] lm_rdata;
    logic [7:0]    kw_buf_reg [KW_MAX_LEN];
    logic          kw_buf_we;

    always_ff @(posedge clk)
    begin
        if (wm_we)
            word_mem[wm_waddr] <= wm_wdata;
        wm_rdata <= word_mem[wm_raddr];
        if (im_we)
            ident_mem[im_waddr] <= wm_rdata;
        im_rdata <= ident_mem[im_raddr];
        if (lm_we)
            len_mem[icount_reg[TW-1:0]] <= wlen_reg;
        lm_rdata <= len_mem[entry_next[TW-1:0]];
        if (kw_buf_we && pos_reg[WW:0] <= (WW+1)'(KW_MAX_LEN) && pos_reg != '0)
            kw_buf_reg[3'(pos_reg - 1'b1)] <= wm_rdata;
    end

    // scanning of one byte from the idle mode
    function automatic void scan_byte(
        input  logic [7:0] c,
        output logic [1:0] mode_o,
        output logic       emit_o,
        output token_t     t_o,
        output logic [1:0] pend_o
    );
        mode_o = MODE_IDLE;
        emit_o = 1'b0;
        t_o    = '0;
        pend_o = PEND_COLON;
        if (is_letter(c))
            mode_o = MODE_WORD;
        else if (is_digit(c))
            mode_o = MODE_NUMBER;
        else if (c == "+" || c == "-" || c == "*" || c == "/")
        begin
            emit_o = 1'b1;
            t_o.cls = CLS_ARITH;
            t_o.idx = (c == "+") ? 16'd0 : (c == "-") ? 16'd1 : (c == "*") ? 16'd2 : 16'd3;
        end
        else if (c == "<" || c == "=" || c == ">" || c == ":")
        begin
            mode_o = MODE_PENDING;
            pend_o = (c == "<") ? PEND_LT : (c == "=") ? PEND_EQ :
                     (c == ">") ? PEND_GT : PEND_COLON;
        end
        else if (c == "," || c == ";" || c == "{" || c == "}" || c == "(" || c == ")")
        begin
            emit_o = 1'b1;
            t_o.cls = CLS_DELIM;
            t_o.idx = (c == ",") ? 16'd0 : (c == ";") ? 16'd1 : (c == "{") ? 16'd2 :
                      (c == "}") ? 16'd3 : (c == "(") ? 16'd4 : 16'd5;
        end
        else if (c != 8'h20 && c != 8'h0A)
        begin
            emit_o = 1'b1;
            t_o.cls = CLS_ERROR;
            t_o.idx = ERR_BADCHAR;
            t_o.bad = c;
        end
    endfunction

    // rescan of the held byte after a finished word
    task automatic tail(
        input  logic [7:0] c,
        input  logic       eot,
        input  token_t     first,
        output logic [1:0] mode_o,
        output logic [1:0] pend_o,
        output token_t     t0,
        output token_t     t1,
        output logic [1:0] n_o
    );
        logic   em;
        token_t tt;
        logic [1:0] m;
        logic [1:0] p;
        scan_byte(c, m, em, tt, p);
        t0 = first;
        t1 = tt;
        mode_o = eot ? MODE_IDLE : m;
        pend_o = eot ? PEND_COLON : p;
        n_o = (!eot && em) ? 2'd2 : 2'd1;
    endtask

    logic         s_emit;
    token_t       s_tok;
    logic [1:0]   s_mode, s_pend;
    logic         word_ch;
    logic         kw_hit;
    logic [2:0]   kw_idx;
    logic [19:0]  num_wide;
    token_t       wtok;
    logic [1:0]   t_mode, t_pend, t_n;
    token_t       t_t0, t_t1;

    assign stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign token_class = tok_reg[osel_reg].cls;
    assign token_index = tok_reg[osel_reg].idx;
    assign bad_char = tok_reg[osel_reg].bad;
    assign last_of_run = (2'(osel_reg) + 2'd1 == ntok_reg);

    // keyword match on the buffered word
    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            logic eq;
            eq = (wlen_reg == LW'(KW_LEN[k]));
            for (int j = 0; j < KW_MAX_LEN; j++)
                if (j < int'(KW_LEN[k]) && kw_buf_reg[j] != KW_TEXT[k][8*(KW_MAX_LEN-j)-1 -: 8])
                    eq = 1'b0;
            if (eq)
            begin
                kw_hit = 1'b1;
                kw_idx = 3'(k);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        wlen_next = wlen_reg;
        num_next = num_reg;
        pend_next = pend_reg;
        icount_next = icount_reg;
        entry_next = entry_reg;
        pos_next = pos_reg;
        hold_ch_next = hold_ch_reg;
        hold_end_next = hold_end_reg;
        tok_next[0] = tok_reg[0];
        tok_next[1] = tok_reg[1];
        ntok_next = ntok_reg;
        osel_next = osel_reg;
        wm_we = 1'b0;
        wm_waddr = wlen_reg[WW-1:0];
        wm_wdata = ch;
        wm_raddr = pos_reg[WW-1:0];
        im_we = 1'b0;
        im_waddr = {icount_reg[TW-1:0], pos_reg[WW-1:0]};
        im_raddr = {entry_reg[TW-1:0], pos_reg[WW-1:0]};
        lm_we = 1'b0;
        kw_buf_we = 1'b0;
        word_ch = is_letter(ch) || is_digit(ch);
        scan_byte(ch, s_mode, s_emit, s_tok, s_pend);
        num_wide = 20'(num_reg) * 20'd10 + 20'(ch - "0");
        wtok = '0;
        tail(hold_ch_reg, hold_end_reg, wtok, t_mode, t_pend, t_t0, t_t1, t_n);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (valid)
                begin
                    ntok_next = 2'd0;
                    osel_next = 1'b0;
                    tok_next[0] = '0;
                    tok_next[1] = s_tok;
                    unique case (mode_reg)
                        MODE_WORD:
                        begin
                            if (!end_of_text && word_ch)
                            begin
                                if (wlen_reg < LW'(MAX_WORD_LEN))
                                    wm_we = 1'b1;
                                if (wlen_reg <= LW'(MAX_WORD_LEN))
                                    wlen_next = wlen_reg + 1'b1;
                            end
                            else
                            begin
                                hold_ch_next = ch;
                                hold_end_next = end_of_text;
                                pos_next = '0;
                                state_next = ST_KWRD;
                            end
                        end
                        MODE_NUMBER:
                        begin
                            if (!end_of_text && is_digit(ch))
                                num_next = (num_wide > 20'd65535) ? 16'hFFFF : num_wide[15:0];
                            else
                            begin
                                tok_next[0] = '{CLS_CONST, num_reg, 8'd0};
                                num_next = '0;
                                mode_next = end_of_text ? MODE_IDLE : s_mode;
                                pend_next = s_pend;
                                ntok_next = (!end_of_text && s_emit) ? 2'd2 : 2'd1;
                                state_next = ST_EMIT;
                            end
                        end
                        MODE_PENDING:
                        begin
                            mode_next = end_of_text ? MODE_IDLE : s_mode;
                            ntok_next = (!end_of_text && s_emit) ? 2'd2 : 2'd1;
                            state_next = ST_EMIT;
                            if (pend_reg == PEND_COLON)
                            begin
                                if (!end_of_text && ch == "=")
                                begin
                                    tok_next[0] = '{CLS_DELIM, 16'd2, 8'd0};
                                    mode_next = MODE_IDLE;
                                    ntok_next = 2'd1;
                                end
                                else
                                    tok_next[0] = '{CLS_ERROR, ERR_LONECOLON, 8'd0};
                            end
                            else if (!end_of_text && pend_reg == PEND_LT && ch == "=")
                            begin
                                tok_next[0] = '{CLS_REL, 16'd1, 8'd0};
                                mode_next = MODE_IDLE;
                                ntok_next = 2'd1;
                            end
                            else if (!end_of_text && pend_reg == PEND_LT && ch == ">")
                            begin
                                tok_next[0] = '{CLS_REL, 16'd5, 8'd0};
                                mode_next = MODE_IDLE;
                                ntok_next = 2'd1;
                            end
                            else if (!end_of_text && pend_reg == PEND_GT && ch == "=")
                            begin
                                tok_next[0] = '{CLS_REL, 16'd4, 8'd0};
                                mode_next = MODE_IDLE;
                                ntok_next = 2'd1;
                            end
                            else
                                tok_next[0] = '{CLS_REL,
                                    (pend_reg == PEND_LT) ? 16'd0 :
                                    (pend_reg == PEND_EQ) ? 16'd2 : 16'd3, 8'd0};
                            if (mode_next == MODE_PENDING)
                                pend_next = s_pend;
                        end
                        default:
                        begin
                            if (!end_of_text)
                            begin
                                mode_next = s_mode;
                                pend_next = s_pend;
                                tok_next[0] = s_tok;
                                if (s_emit)
                                begin
                                    ntok_next = 2'd1;
                                    state_next = ST_EMIT;
                                end
                            end
                        end
                    endcase
                    if (!end_of_text && s_mode == MODE_WORD && mode_next == MODE_WORD
                        && mode_reg != MODE_WORD)
                    begin
                        wm_waddr = '0;
                        wm_we = 1'b1;
                        wlen_next = LW'(1);
                    end
                    if (!end_of_text && s_mode == MODE_NUMBER && mode_next == MODE_NUMBER
                        && mode_reg != MODE_NUMBER)
                        num_next = 16'(ch - "0");
                end
            end
            // read word characters into the keyword buffer
            ST_KWRD:
            begin
                kw_buf_we = 1'b1;
                wm_raddr = pos_reg[WW-1:0];
                pos_next = pos_reg + 1'b1;
                if (pos_reg == (WW+1)'(KW_MAX_LEN) || pos_reg == (WW+1)'(MAX_WORD_LEN))
                    state_next = ST_KW;
            end
            ST_KW:
            begin
                entry_next = '0;
                if (wlen_reg > LW'(MAX_WORD_LEN))
                    wtok = '{CLS_ERROR, ERR_TOOLONG, 8'd0};
                else if (kw_hit)
                    wtok = '{CLS_KEYWORD, 16'(kw_idx), 8'd0};
                if (wlen_reg > LW'(MAX_WORD_LEN) || kw_hit)
                begin
                    tail(hold_ch_reg, hold_end_reg, wtok, t_mode, t_pend,
                         t_t0, t_t1, t_n);
                    tok_next[0] = t_t0;
                    tok_next[1] = t_t1;
                    ntok_next = t_n;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_LEN;
            end
            // length of entry_reg is being read
            ST_LEN:
            begin
                if (entry_reg == icount_reg)
                begin
                    if (icount_reg == CW'(TABLE_DEPTH))
                    begin
                        wtok = '{CLS_ERROR, ERR_TABLEFULL, 8'd0};
                        tail(hold_ch_reg, hold_end_reg, wtok, t_mode, t_pend,
                             t_t0, t_t1, t_n);
                        tok_next[0] = t_t0;
                        tok_next[1] = t_t1;
                        ntok_next = t_n;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pos_next = '0;
                        state_next = ST_COPY;
                    end
                end
                else
                    state_next = ST_LENCHK;
            end
            ST_LENCHK:
            begin
                pos_next = '0;
                if (lm_rdata == wlen_reg)
                    state_next = ST_CMP;
                else
                begin
                    entry_next = entry_reg + 1'b1;
                    state_next = ST_LEN;
                end
            end
            // issue reads of both characters at pos_reg
            ST_CMP:
            begin
                if (pos_reg == (WW+1)'(wlen_reg))
                begin
                    wtok = '{CLS_IDENT, 16'(entry_reg), 8'd0};
                    tail(hold_ch_reg, hold_end_reg, wtok, t_mode, t_pend,
                         t_t0, t_t1, t_n);
                    tok_next[0] = t_t0;
                    tok_next[1] = t_t1;
                    ntok_next = t_n;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_CMPCHK;
            end
            ST_CMPCHK:
            begin
                if (wm_rdata == im_rdata)
                begin
                    pos_next = pos_reg + 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    entry_next = entry_reg + 1'b1;
                    state_next = ST_LEN;
                end
            end
            // copy the word into a new entry, one character a step
            ST_COPY:
            begin
                if (pos_reg == (WW+1)'(wlen_reg))
                begin
                    lm_we = 1'b1;
                    icount_next = icount_reg + 1'b1;
                    wtok = '{CLS_IDENT, 16'(icount_reg), 8'd0};
                    tail(hold_ch_reg, hold_end_reg, wtok, t_mode, t_pend,
                         t_t0, t_t1, t_n);
                    tok_next[0] = t_t0;
                    tok_next[1] = t_t1;
                    ntok_next = t_n;
                    state_next = ST_EMIT;
                end
                else
                    state_next = ST_COPYWR;
            end
            ST_COPYWR:
            begin
                im_we = 1'b1;
                pos_next = pos_reg + 1'b1;
                state_next = ST_COPY;
            end
            ST_EMIT:
            begin
                if (out_valid_reg && !out_stall)
                begin
                    if (2'(osel_reg) + 2'd1 == ntok_reg)
                        state_next = ST_IDLE;
                    else
                        osel_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        // the held byte's mode once a word has resolved
        if ((state_reg != ST_IDLE) && (state_next == ST_EMIT) && (state_reg != ST_EMIT)
            && mode_reg == MODE_WORD)
        begin
            mode_next = t_mode;
            pend_next = t_pend;
            wlen_next = '0;
            if (t_mode == MODE_WORD)
            begin
                wm_we = 1'b1;
                wm_waddr = '0;
                wm_wdata = hold_ch_reg;
                wlen_next = LW'(1);
            end
            if (t_mode == MODE_NUMBER)
                num_next = 16'(hold_ch_reg - "0");
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg <= MODE_IDLE;
            wlen_reg <= '0;
            num_reg <= '0;
            pend_reg <= PEND_COLON;
            icount_reg <= '0;
            ntok_reg <= '0;
            osel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            wlen_reg <= wlen_next;
            num_reg <= num_next;
            pend_reg <= pend_next;
            icount_reg <= icount_next;
            ntok_reg <= ntok_next;
            osel_reg <= osel_next;
            out_valid_reg <= (state_next == ST_EMIT);
        end
    end

    // payload and sequencing registers without reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        pos_reg <= pos_next;
        hold_ch_reg <= hold_ch_next;
        hold_end_reg <= hold_end_next;
        tok_reg[0] <= tok_next[0];
        tok_reg[1] <= tok_next[1];
    end
endmodule

/* test/lexical_token_scanner_unit_test.sv */
// Testbench for lexical_token_scanner_unit: drives source bytes, predicts the
// token stream with its own scanner model and checks every output beat.
// Depends on lts_pkg and the scanner RTL.
`timescale 1ns / 1ps
module lexical_token_scanner_unit_test;
    import lts_pkg::*;

    localparam int TABLE_DEPTH  = 32;
    localparam int MAX_WORD_LEN = 16;
    localparam int CYCLE_LIMIT  = 10000000;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } byte_beat_t;

    typedef struct packed {
        logic [2:0]  cls;
        logic [15:0] idx;
        logic [7:0]  bad;
        logic        last;
    } token_beat_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        stall;
    logic [7:0]  ch;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  token_class;
    logic [15:0] token_index;
    logic [7:0]  bad_char;
    logic        last_of_run;

    lexical_token_scanner_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_WORD_LEN(MAX_WORD_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (valid),
        .stall      (stall),
        .ch         (ch),
        .end_of_text(end_of_text),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_class(token_class),
        .token_index(token_index),
        .bad_char   (bad_char),
        .last_of_run(last_of_run)
    );

    byte_beat_t  source_queue[$];
    token_beat_t token_queue[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          cycle_count;

    // scanner state of the predictor
    logic [1:0]  sc_mode;
    logic [7:0]  sc_word [MAX_WORD_LEN];
    int          sc_len;
    int          sc_num;
    logic [1:0]  sc_rel;
    logic [7:0]  id_chars [TABLE_DEPTH][MAX_WORD_LEN];
    int          id_len [TABLE_DEPTH];
    int          id_count;
    token_beat_t step_tokens[$];

    string kw_words[8] = '{"if", "else", "for", "while", "do", "return", "break",
                           "continue"};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic bit letter_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic bit digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    task automatic emit(input logic [2:0] cls, input int idx, input logic [7:0] bad);
        token_beat_t t;
        t.cls  = cls;
        t.idx  = idx[15:0];
        t.bad  = bad;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic close_word();
        bit hit;
        if (sc_len > MAX_WORD_LEN)
        begin
            emit(CLS_ERROR, ERR_TOOLONG, 8'h00);
            return;
        end
        for (int k = 0; k < 8; k++)
        begin
            hit = (kw_words[k].len() == sc_len);
            for (int j = 0; hit && j < sc_len; j++)
                if (kw_words[k][j] != sc_word[j]) hit = 0;
            if (hit)
            begin
                emit(CLS_KEYWORD, k, 8'h00);
                return;
            end
        end
        for (int k = 0; k < id_count; k++)
        begin
            hit = (id_len[k] == sc_len);
            for (int j = 0; hit && j < sc_len; j++)
                if (id_chars[k][j] != sc_word[j]) hit = 0;
            if (hit)
            begin
                emit(CLS_IDENT, k, 8'h00);
                return;
            end
        end
        if (id_count >= TABLE_DEPTH)
        begin
            emit(CLS_ERROR, ERR_TABLEFULL, 8'h00);
            return;
        end
        for (int j = 0; j < sc_len; j++) id_chars[id_count][j] = sc_word[j];
        id_len[id_count] = sc_len;
        emit(CLS_IDENT, id_count, 8'h00);
        id_count++;
    endtask

    task automatic scan_fresh(input logic [7:0] c);
        if (letter_char(c))
        begin
            sc_mode = MODE_WORD;
            sc_word[0] = c;
            sc_len = 1;
        end
        else if (digit_char(c))
        begin
            sc_mode = MODE_NUMBER;
            sc_num = c - 8'h30;
        end
        else if (c == "+") emit(CLS_ARITH, 0, 8'h00);
        else if (c == "-") emit(CLS_ARITH, 1, 8'h00);
        else if (c == "*") emit(CLS_ARITH, 2, 8'h00);
        else if (c == "/") emit(CLS_ARITH, 3, 8'h00);
        else if (c == "<" || c == "=" || c == ">" || c == ":")
        begin
            sc_mode = MODE_PENDING;
            sc_rel = (c == "<") ? PEND_LT : (c == "=") ? PEND_EQ :
                     (c == ">") ? PEND_GT : PEND_COLON;
        end
        else if (c == ",") emit(CLS_DELIM, 0, 8'h00);
        else if (c == ";") emit(CLS_DELIM, 1, 8'h00);
        else if (c == "{") emit(CLS_DELIM, 2, 8'h00);
        else if (c == "}") emit(CLS_DELIM, 3, 8'h00);
        else if (c == "(") emit(CLS_DELIM, 4, 8'h00);
        else if (c == ")") emit(CLS_DELIM, 5, 8'h00);
        else if (c != 8'h20 && c != 8'h0a) emit(CLS_ERROR, ERR_BADCHAR, c);
    endtask

    // predict the tokens of one accepted byte and queue them
    task automatic predict_tokens(input byte_beat_t b);
        bit rescan;
        int two;
        rescan = 1;
        step_tokens.delete();
        if (sc_mode == MODE_WORD)
        begin
            if (!b.eot && (letter_char(b.ch) || digit_char(b.ch)))
            begin
                if (sc_len < MAX_WORD_LEN) sc_word[sc_len] = b.ch;
                if (sc_len <= MAX_WORD_LEN) sc_len++;
                return;
            end
            close_word();
            sc_mode = MODE_IDLE;
            sc_len = 0;
        end
        else if (sc_mode == MODE_NUMBER)
        begin
            if (!b.eot && digit_char(b.ch))
            begin
                sc_num = sc_num * 10 + (b.ch - 8'h30);
                if (sc_num > 65535) sc_num = 65535;
                return;
            end
            emit(CLS_CONST, sc_num, 8'h00);
            sc_mode = MODE_IDLE;
            sc_num = 0;
        end
        else if (sc_mode == MODE_PENDING)
        begin
            sc_mode = MODE_IDLE;
            two = -1;
            if (sc_rel == PEND_COLON)
            begin
                if (!b.eot && b.ch == "=") emit(CLS_DELIM, 2, 8'h00);
                else emit(CLS_ERROR, ERR_LONECOLON, 8'h00);
                if (!b.eot && b.ch == "=") rescan = 0;
            end
            else
            begin
                if (!b.eot)
                begin
                    if (sc_rel == PEND_LT && b.ch == "=") two = 1;
                    else if (sc_rel == PEND_LT && b.ch == ">") two = 5;
                    else if (sc_rel == PEND_GT && b.ch == "=") two = 4;
                end
                if (two >= 0)
                begin
                    emit(CLS_REL, two, 8'h00);
                    rescan = 0;
                end
                else emit(CLS_REL, (sc_rel == PEND_LT) ? 0 : (sc_rel == PEND_EQ) ? 2 : 3,
                          8'h00);
            end
            sc_rel = PEND_COLON;
        end
        if (rescan && !b.eot) scan_fresh(b.ch);
        if (b.eot) sc_mode = MODE_IDLE;
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[k]) token_queue.push_back(step_tokens[k]);
    endtask

    // stimulus helpers
    task automatic push_byte(input logic [7:0] c, input logic eot);
        byte_beat_t b;
        b.ch  = c;
        b.eot = eot;
        source_queue.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k], 1'b0);
    endtask

    function automatic string random_word(input int maxlen);
        string s;
        int n;
        s = "";
        n = $urandom_range(1, maxlen);
        for (int k = 0; k < n; k++)
        begin
            if (k > 0 && $urandom_range(0, 3) == 0)
                s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
            else if ($urandom_range(0, 1))
                s = {s, string'(byte'(8'h61 + $urandom_range(0, 25)))};
            else
                s = {s, string'(byte'(8'h41 + $urandom_range(0, 25)))};
        end
        return s;
    endfunction

    // mostly well-formed program text, some raw noise
    task automatic push_random_phrase();
        int pick;
        string ops[] = '{"+", "-", "*", "/", ",", ";", "{", "}", "(", ")", "<", "<=",
                         ">", ">=", "<>", "=", ":=", ":", " ", "\n"};
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            // small name pool so identifiers recur
            if ($urandom_range(0, 2) == 0) push_text(random_word(18));
            else push_text({"v", string'(byte'(8'h61 + $urandom_range(0, 5)))});
        end
        else if (pick < 38) push_text(kw_words[$urandom_range(0, 7)]);
        else if (pick < 50)
        begin
            if ($urandom_range(0, 3) == 0) push_text("99999999");
            else push_text($sformatf("%0d", $urandom_range(0, 70000)));
        end
        else if (pick < 85) push_text(ops[$urandom_range(0, ops.size() - 1)]);
        else if (pick < 95) push_byte(8'($urandom_range(0, 255)), 1'b0);
        else push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // driver: offers the next pending beat, with random idle gaps, once the previous one was taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid       <= 1'b0;
            ch          <= 8'h00;
            end_of_text <= 1'b0;
        end
        else
        begin
            if (valid && !stall) predict_tokens('{ch: ch, eot: end_of_text});
            if (!valid || !stall)
            begin
                if (source_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    valid       <= 1'b1;
                    ch          <= source_queue[0].ch;
                    end_of_text <= source_queue[0].eot;
                    void'(source_queue.pop_front());
                end
                else
                    valid <= 1'b0;
            end
        end
    end

    // receiver stall generation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // monitor: compare each token beat against the oldest prediction
    always @(posedge clk)
    begin
        token_beat_t exp_tok;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_queue.size() == 0)
                report_mismatch($sformatf("unexpected token cls %0d idx %0d",
                                          token_class, token_index));
            else
            begin
                exp_tok = token_queue.pop_front();
                if (token_class !== exp_tok.cls)
                    report_mismatch($sformatf("class %0d, want %0d", token_class, exp_tok.cls));
                if (token_index !== exp_tok.idx)
                    report_mismatch($sformatf("index %0d, want %0d", token_index, exp_tok.idx));
                if (bad_char !== exp_tok.bad)
                    report_mismatch($sformatf("bad_char %h, want %h", bad_char, exp_tok.bad));
                if (last_of_run !== exp_tok.last)
                    report_mismatch($sformatf("last %b, want %b", last_of_run, exp_tok.last));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic run_phase(input int idle_pct, input int stall_pct, input int beats);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < beats; k++) push_random_phrase();
        while (source_queue.size() > 0 || valid) @(posedge clk);
    endtask

    initial
    begin
        fail_count     = 0;
        cycle_count    = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sc_mode        = MODE_IDLE;
        sc_len         = 0;
        sc_num         = 0;
        sc_rel         = PEND_COLON;
        id_count       = 0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: keywords, operators, relations, colon cases, limits
        push_text("if else for while do return break continue ");
        push_text("x1 x1 Ab9 <= >= <> < = > ;");
        push_text(":= : x 65535 65536 0 ");
        push_byte(8'h09, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_text("abcdefghijklmnopq continuex whilea ");
        push_text("<");
        push_byte(8'h00, 1'b1);
        push_text(":");
        push_byte(8'hff, 1'b1);
        push_text("77");
        push_byte(8'h3d, 1'b1);
        push_byte(8'h00, 1'b1);
        push_text("+-*/,{}()");
        run_phase(0, 0, 0);

        run_phase(0, 0, 70);
        run_phase(47, 0, 70);
        run_phase(0, 47, 70);
        run_phase(13, 13, 70);

        // long receiver hold-off while the sender keeps offering
        hold_cycles = 300;
        run_phase(0, 0, 60);

        // fill the identifier table past its depth
        for (int k = 0; k < TABLE_DEPTH + 4; k++) push_text($sformatf("tz%0d ", k));
        push_text("tz0 vz ");
        run_phase(13, 13, 30);
        push_byte(8'h00, 1'b1);
        run_phase(0, 0, 0);

        while (token_queue.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
